// ----- hdl/bfa_pkg.sv -----
// bfa_pkg: shared types and constants for the best-fit allocator.
// Holds cell command encoding, controller states and status codes.
// No dependencies.
`default_nettype none

package bfa_pkg;

    // Command broadcast to every cell of the free-area chain
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INIT,
        OP_ROTATE,
        OP_SORT,
        OP_COMPACT,
        OP_UPDATE,
        OP_APPEND
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     phase;   // odd/even pair select for sort and compact
    } cell_cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_DECIDE,
        S_SORT,
        S_MERGE,
        S_COMPACT
    } bfa_state_t;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NOFIT   = 2'd1;
    localparam logic [1:0] STAT_BADSIZE = 2'd2;
    localparam logic [1:0] STAT_FULL    = 2'd3;

    localparam int MEM_SIZE_RST = 65536;

endpackage

`default_nettype wire

// ----- hdl/bfa_cell.sv -----
// bfa_cell: one free-area slot of the chain (valid, base, size).
// Trades entries with its neighbors on rotate and odd-even sort steps.
// Depends on bfa_pkg.
`default_nettype none

module bfa_cell #(
    parameter int IDX       = 0,
    parameter int MAX_AREAS = 64,
    parameter int ADDR_BITS = 16,
    parameter int IDXW      = 6,
    parameter logic [ADDR_BITS:0] RST_SIZE = '0
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire bfa_pkg::cell_cmd_t      cmd,
    input  wire logic [IDXW-1:0]         arg_idx,
    input  wire logic [ADDR_BITS-1:0]    arg_base,
    input  wire logic [ADDR_BITS:0]      arg_size,
    input  wire logic                    left_v,
    input  wire logic [ADDR_BITS-1:0]    left_b,
    input  wire logic [ADDR_BITS:0]      left_s,
    input  wire logic                    right_v,
    input  wire logic [ADDR_BITS-1:0]    right_b,
    input  wire logic [ADDR_BITS:0]      right_s,
    output logic                         v,
    output logic [ADDR_BITS-1:0]         b,
    output logic [ADDR_BITS:0]           s
);
    import bfa_pkg::*;

    localparam logic            PAR     = ((IDX % 2) == 1);
    localparam logic            IS_HEAD = (IDX == 0);
    localparam logic            IS_TAIL = (IDX == MAX_AREAS - 1);
    localparam logic [IDXW-1:0] MY_IDX  = IDXW'(IDX);

    logic                 v_reg, v_next;
    logic [ADDR_BITS-1:0] b_reg, b_next;
    logic [ADDR_BITS:0]   s_reg, s_next;
    logic                 by_base;
    logic                 swap_r, swap_l;

    always_comb
    begin
        v_next  = v_reg;
        b_next  = b_reg;
        s_next  = s_reg;
        by_base = (cmd.op == OP_SORT);
        // pair (self, right) and pair (left, self); empty slots sink to the end
        swap_r = (!v_reg && right_v) ||
                 (by_base && v_reg && right_v && (b_reg > right_b));
        swap_l = (!left_v && v_reg) ||
                 (by_base && left_v && v_reg && (left_b > b_reg));
        case (cmd.op)
            OP_INIT:
            begin
                v_next = IS_HEAD;
                b_next = '0;
                s_next = arg_size;
            end
            OP_ROTATE:
            begin
                v_next = right_v;
                b_next = right_b;
                s_next = right_s;
            end
            OP_SORT, OP_COMPACT:
            begin
                if (PAR == cmd.phase)
                begin
                    if (!IS_TAIL && swap_r)
                    begin
                        v_next = right_v;
                        b_next = right_b;
                        s_next = right_s;
                    end
                end
                else if (!IS_HEAD && swap_l)
                begin
                    v_next = left_v;
                    b_next = left_b;
                    s_next = left_s;
                end
            end
            OP_UPDATE:
            begin
                if (arg_idx == MY_IDX)
                begin
                    if (s_reg > arg_size)
                    begin
                        b_next = b_reg + arg_size[ADDR_BITS-1:0];
                        s_next = s_reg - arg_size;
                    end
                    else
                    begin
                        v_next = 1'b0;
                    end
                end
            end
            OP_APPEND:
            begin
                if (arg_idx == MY_IDX)
                begin
                    v_next = 1'b1;
                    b_next = arg_base;
                    s_next = arg_size;
                end
            end
            default:
            begin
                v_next = v_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= IS_HEAD;
            b_reg <= '0;
            s_reg <= IS_HEAD ? RST_SIZE : '0;
        end
        else
        begin
            v_reg <= v_next;
            b_reg <= b_next;
            s_reg <= s_next;
        end
    end

    assign v = v_reg;
    assign b = b_reg;
    assign s = s_reg;

endmodule

`default_nettype wire

// ----- hdl/bfa_ctrl.sv -----
// bfa_ctrl: request sequencer for the allocator; drives chain commands
// and watches the head cell. Depends on bfa_pkg.
`default_nettype none

module bfa_ctrl #(
    parameter int MAX_AREAS = 64,
    parameter int ADDR_BITS = 16,
    parameter int IDXW      = 6,
    parameter int CW        = 7,
    parameter logic [ADDR_BITS:0] RST_SIZE = '0
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  func,
    input  wire logic [ADDR_BITS:0]    req_size,
    input  wire logic [ADDR_BITS-1:0]  free_base,
    input  wire logic                  cfg_we,
    input  wire logic [ADDR_BITS:0]    cfg_wdata,
    output logic                       done,
    output logic [1:0]                 status,
    output logic [ADDR_BITS-1:0]       alloc_base,
    output logic                       did_reclaim,
    output bfa_pkg::cell_cmd_t         cmd,
    output logic [IDXW-1:0]            arg_idx,
    output logic [ADDR_BITS-1:0]       arg_base,
    output logic [ADDR_BITS:0]         arg_size,
    output logic                       tail_v,
    output logic [ADDR_BITS-1:0]       tail_b,
    output logic [ADDR_BITS:0]         tail_s,
    input  wire logic                  head_v,
    input  wire logic [ADDR_BITS-1:0]  head_b,
    input  wire logic [ADDR_BITS:0]    head_s
);
    import bfa_pkg::*;

    localparam int SW = ADDR_BITS + 1;

    bfa_state_t           state_reg, state_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [SW-1:0]        msize_reg, msize_next;
    logic [SW-1:0]        want_reg, want_next;
    logic [SW-1:0]        best_s_reg, best_s_next;
    logic [IDXW-1:0]      best_i_reg, best_i_next;
    logic [ADDR_BITS-1:0] best_b_reg, best_b_next;
    logic                 found_reg, found_next;
    logic                 stop_reg, stop_next;
    logic                 recl_reg, recl_next;
    logic                 changed_reg, changed_next;
    logic                 to_search_reg, to_search_next;
    logic                 acc_v_reg, acc_v_next;
    logic [ADDR_BITS-1:0] acc_b_reg, acc_b_next;
    logic [SW-1:0]        acc_s_reg, acc_s_next;
    logic                 done_reg, done_next;
    logic [1:0]           stat_reg, stat_next;
    logic [ADDR_BITS-1:0] abase_reg, abase_next;
    logic                 orecl_reg, orecl_next;

    logic                 last_n;
    logic [SW:0]          acc_end;
    logic [SW:0]          size_sum;
    logic                 adj;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        count_next     = count_reg;
        msize_next     = msize_reg;
        want_next      = want_reg;
        best_s_next    = best_s_reg;
        best_i_next    = best_i_reg;
        best_b_next    = best_b_reg;
        found_next     = found_reg;
        stop_next      = stop_reg;
        recl_next      = recl_reg;
        changed_next   = changed_reg;
        to_search_next = to_search_reg;
        acc_v_next     = acc_v_reg;
        acc_b_next     = acc_b_reg;
        acc_s_next     = acc_s_reg;
        done_next      = 1'b0;
        stat_next      = stat_reg;
        abase_next     = abase_reg;
        orecl_next     = orecl_reg;

        cmd.op    = OP_HOLD;
        cmd.phase = cnt_reg[0];
        arg_idx   = best_i_reg;
        arg_base  = free_base;
        arg_size  = want_reg;
        tail_v    = head_v;
        tail_b    = head_b;
        tail_s    = head_s;

        last_n   = (cnt_reg == CW'(MAX_AREAS - 1));
        acc_end  = (SW+1)'(acc_b_reg) + (SW+1)'(acc_s_reg);
        size_sum = (SW+1)'(acc_s_reg) + (SW+1)'(head_s);
        adj      = acc_v_reg && head_v && ((SW+1)'(head_b) == acc_end);

        case (state_reg)
            S_IDLE:
            begin
                if (cfg_we)
                begin
                    msize_next = cfg_wdata;
                    count_next = CW'(1);
                    cmd.op     = OP_INIT;
                    arg_size   = cfg_wdata;
                end
                else if (start)
                begin
                    abase_next = '0;
                    orecl_next = 1'b0;
                    stat_next  = STAT_OK;
                    if ((req_size == '0) || (req_size > msize_reg))
                    begin
                        stat_next = STAT_BADSIZE;
                        done_next = 1'b1;
                    end
                    else if (func)
                    begin
                        done_next = 1'b1;
                        if (count_reg == CW'(MAX_AREAS))
                        begin
                            stat_next = STAT_FULL;
                        end
                        else
                        begin
                            cmd.op     = OP_APPEND;
                            arg_idx    = count_reg[IDXW-1:0];
                            arg_size   = req_size;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        stat_next = STAT_NOFIT;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        want_next  = req_size;
                        recl_next  = 1'b0;
                        cnt_next   = '0;
                        found_next = 1'b0;
                        stop_next  = 1'b0;
                        state_next = S_SEARCH;
                    end
                end
            end
            S_SEARCH:
            begin
                // head cell holds entry number cnt_reg; write it back unchanged
                cmd.op = OP_ROTATE;
                if ((cnt_reg < count_reg) && !stop_reg)
                begin
                    if (head_s == want_reg)
                    begin
                        best_s_next = head_s;
                        best_i_next = cnt_reg[IDXW-1:0];
                        best_b_next = head_b;
                        found_next  = 1'b1;
                        stop_next   = 1'b1;
                    end
                    else if ((head_s > want_reg) && (!found_reg || (head_s < best_s_reg)))
                    begin
                        best_s_next = head_s;
                        best_i_next = cnt_reg[IDXW-1:0];
                        best_b_next = head_b;
                        found_next  = 1'b1;
                    end
                end
                cnt_next = cnt_reg + CW'(1);
                if (last_n)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (found_reg)
                begin
                    cmd.op     = OP_UPDATE;
                    stat_next  = STAT_OK;
                    abase_next = best_b_reg;
                    orecl_next = recl_reg;
                    if (best_s_reg == want_reg)
                    begin
                        // exact fit leaves a hole; close it up before finishing
                        count_next     = count_reg - CW'(1);
                        to_search_next = 1'b0;
                        cnt_next       = '0;
                        state_next     = S_COMPACT;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (recl_reg)
                begin
                    stat_next  = STAT_NOFIT;
                    abase_next = '0;
                    orecl_next = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    recl_next  = 1'b1;
                    cnt_next   = '0;
                    state_next = S_SORT;
                end
            end
            S_SORT:
            begin
                cmd.op   = OP_SORT;
                cnt_next = cnt_reg + CW'(1);
                if (last_n)
                begin
                    cnt_next     = '0;
                    acc_v_next   = 1'b0;
                    changed_next = 1'b0;
                    state_next   = S_MERGE;
                end
            end
            S_MERGE:
            begin
                // one extra rotation flushes the open run; the first write is a hole
                cmd.op   = OP_ROTATE;
                tail_v   = 1'b0;
                tail_b   = acc_b_reg;
                tail_s   = acc_s_reg;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(MAX_AREAS))
                begin
                    // holes are left between runs either way; compact always
                    tail_v         = acc_v_reg;
                    to_search_next = changed_reg;
                    cnt_next       = '0;
                    state_next     = S_COMPACT;
                    if (!changed_reg)
                    begin
                        stat_next  = STAT_NOFIT;
                        abase_next = '0;
                        orecl_next = 1'b1;
                    end
                end
                else if (adj)
                begin
                    acc_s_next   = size_sum[SW] ? '1 : size_sum[SW-1:0];
                    changed_next = 1'b1;
                    count_next   = count_reg - CW'(1);
                end
                else if (head_v)
                begin
                    tail_v     = acc_v_reg;
                    acc_v_next = 1'b1;
                    acc_b_next = head_b;
                    acc_s_next = head_s;
                end
            end
            S_COMPACT:
            begin
                cmd.op   = OP_COMPACT;
                cnt_next = cnt_reg + CW'(1);
                if (last_n)
                begin
                    cnt_next = '0;
                    if (to_search_reg)
                    begin
                        found_next = 1'b0;
                        stop_next  = 1'b0;
                        state_next = S_SEARCH;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            count_reg     <= CW'(1);
            msize_reg     <= RST_SIZE;
            found_reg     <= 1'b0;
            stop_reg      <= 1'b0;
            recl_reg      <= 1'b0;
            changed_reg   <= 1'b0;
            to_search_reg <= 1'b0;
            acc_v_reg     <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            count_reg     <= count_next;
            msize_reg     <= msize_next;
            found_reg     <= found_next;
            stop_reg      <= stop_next;
            recl_reg      <= recl_next;
            changed_reg   <= changed_next;
            to_search_reg <= to_search_next;
            acc_v_reg     <= acc_v_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        want_reg   <= want_next;
        best_s_reg <= best_s_next;
        best_i_reg <= best_i_next;
        best_b_reg <= best_b_next;
        acc_b_reg  <= acc_b_next;
        acc_s_reg  <= acc_s_next;
        stat_reg   <= stat_next;
        abase_reg  <= abase_next;
        orecl_reg  <= orecl_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = stat_reg;
    assign alloc_base  = abase_reg;
    assign did_reclaim = orecl_reg;

endmodule

`default_nettype wire

// ----- hdl/best_fit_allocator.sv -----
// best_fit_allocator: top level; best-fit allocator over a chain of
// free-area cells with sort-and-merge reclaim. Depends on bfa_pkg,
// bfa_cell and bfa_ctrl.
`default_nettype none

// Usage
//   Request channel: an item (func, req_size, free_base) transfers on a
//   rising edge with start high, busy and cfg_we low. func 0 allocates
//   req_size units, func 1 returns the area (free_base, req_size) to the
//   table. Result channel: done is high for exactly one cycle with status,
//   alloc_base and did_reclaim; the receiver cannot stall it.
//   Configuration: cfg_we with cfg_wdata writes mem_size while the block
//   is idle and resets the free table to one area (0, mem_size).
// Sequence of a request, driven by the rotating cell chain:
//   free or rejected request: result in the cycle after the transfer.
//   alloc that fits: search, then update; an exact fit adds a compaction
//   (the emptied slot is closed up by an odd-even compaction).
//   alloc that reclaims: search, sort, merge and compaction; a merge
//   adds a second search and, for an exact fit, a second compaction;
//   with no merge the result comes after the compaction.
//   A new request may transfer at the edge that ends the done cycle;
//   after a free or rejected request busy never rises.
// Reset: the table holds one area (0, 65536) and mem_size is 65536; the
//   chain slots are cleared by reset, so no clearing pass is needed.
module best_fit_allocator #(
    parameter int MAX_AREAS = 64,
    parameter int ADDR_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  func,
    input  wire logic [ADDR_BITS:0]    req_size,
    input  wire logic [ADDR_BITS-1:0]  free_base,
    input  wire logic                  cfg_we,
    input  wire logic [ADDR_BITS:0]    cfg_wdata,
    output logic                       done,
    output logic [1:0]                 status,
    output logic [ADDR_BITS-1:0]       alloc_base,
    output logic                       did_reclaim
);
    import bfa_pkg::*;

    localparam int IDXW = (MAX_AREAS > 1) ? $clog2(MAX_AREAS) : 1;
    localparam int CW   = $clog2(MAX_AREAS + 1);
    localparam logic [ADDR_BITS:0] RST_SIZE = (ADDR_BITS+1)'(MEM_SIZE_RST);

    cell_cmd_t            cmd;
    logic [IDXW-1:0]      arg_idx;
    logic [ADDR_BITS-1:0] arg_base;
    logic [ADDR_BITS:0]   arg_size;
    logic                 tail_v;
    logic [ADDR_BITS-1:0] tail_b;
    logic [ADDR_BITS:0]   tail_s;

    // slot outputs of the chain; slot 0 is the head seen by the sequencer
    logic                 cv [MAX_AREAS];
    logic [ADDR_BITS-1:0] cb [MAX_AREAS];
    logic [ADDR_BITS:0]   cs [MAX_AREAS];

    bfa_ctrl #(
        .MAX_AREAS (MAX_AREAS),
        .ADDR_BITS (ADDR_BITS),
        .IDXW      (IDXW),
        .CW        (CW),
        .RST_SIZE  (RST_SIZE)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .req_size    (req_size),
        .free_base   (free_base),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .done        (done),
        .status      (status),
        .alloc_base  (alloc_base),
        .did_reclaim (did_reclaim),
        .cmd         (cmd),
        .arg_idx     (arg_idx),
        .arg_base    (arg_base),
        .arg_size    (arg_size),
        .tail_v      (tail_v),
        .tail_b      (tail_b),
        .tail_s      (tail_s),
        .head_v      (cv[0]),
        .head_b      (cb[0]),
        .head_s      (cs[0])
    );

    genvar g;
    generate
        for (g = 0; g < MAX_AREAS; g++)
        begin : g_cell
            logic                 lv, rv;
            logic [ADDR_BITS-1:0] lb, rb;
            logic [ADDR_BITS:0]   ls, rs;

            if (g == 0)
            begin : g_first
                assign lv = 1'b0;
                assign lb = '0;
                assign ls = '0;
            end
            else
            begin : g_mid_l
                assign lv = cv[g-1];
                assign lb = cb[g-1];
                assign ls = cs[g-1];
            end

            // the last slot is fed by the sequencer's write-back on rotation
            if (g == MAX_AREAS - 1)
            begin : g_last
                assign rv = tail_v;
                assign rb = tail_b;
                assign rs = tail_s;
            end
            else
            begin : g_mid_r
                assign rv = cv[g+1];
                assign rb = cb[g+1];
                assign rs = cs[g+1];
            end

            bfa_cell #(
                .IDX       (g),
                .MAX_AREAS (MAX_AREAS),
                .ADDR_BITS (ADDR_BITS),
                .IDXW      (IDXW),
                .RST_SIZE  (RST_SIZE)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cmd      (cmd),
                .arg_idx  (arg_idx),
                .arg_base (arg_base),
                .arg_size (arg_size),
                .left_v   (lv),
                .left_b   (lb),
                .left_s   (ls),
                .right_v  (rv),
                .right_b  (rb),
                .right_s  (rs),
                .v        (cv[g]),
                .b        (cb[g]),
                .s        (cs[g])
            );
        end
    endgenerate

endmodule

`default_nettype wire

// ----- hdl/bfa_checker.sv -----
// bfa_props: port-level assertions for best_fit_allocator, bound to
// the top level. Depends on bfa_pkg.
`default_nettype none

module bfa_props #(
    parameter int ADDR_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic                  busy,
    input  wire logic                  func,
    input  wire logic                  done,
    input  wire logic [1:0]            status,
    input  wire logic [ADDR_BITS-1:0]  alloc_base,
    input  wire logic                  did_reclaim
);
    import bfa_pkg::*;

    // failed results carry no base
    a_base_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != STAT_OK)) |-> (alloc_base == '0))
        else $error("nonzero alloc_base on failed result");

    // reclaim only happens on alloc, which is never bad-size or full
    a_recl_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && did_reclaim) |-> ((status == STAT_OK) || (status == STAT_NOFIT)))
        else $error("reclaim flagged with wrong status");

    // free requests complete without going busy
    a_free_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func) |=> (done && !busy))
        else $error("free request not answered next cycle");

    // every transfer is answered at once or makes the block busy
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("request dropped");

    // leaving busy always delivers a result
    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy ended without result");

endmodule

bind best_fit_allocator bfa_props #(.ADDR_BITS(ADDR_BITS)) u_bfa_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .func        (func),
    .done        (done),
    .status      (status),
    .alloc_base  (alloc_base),
    .did_reclaim (did_reclaim)
);

`default_nettype wire
